/* hw/rtl/dsdf_pkg.sv */
// Shared constants and types for the dust sensor density filter.
// No dependencies; compile first.
package dsdf_pkg;

  localparam int ADC_W              = 10;
  localparam int MV_W               = 16;
  localparam int DENS_W             = 14;
  localparam int OFFSET_W           = 16;
  localparam int WINDOW_LEN_DEFAULT = 10;

  localparam int ADC_MAX            = (1 << ADC_W) - 1;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 16'd400;

  // Millivolts at full scale: 5000 mV times the divide-by-eleven front end.
  localparam int MV_FULL_SCALE = 55000;
  localparam int MV_FS_W       = 16;
  localparam int SCALED_W      = ADC_W + MV_FS_W;

  // Density is (voltage - offset) / 5, done as a reciprocal multiply.
  // Exact for any 16-bit dividend.
  localparam int DENS_RECIP_SHIFT = 19;
  localparam int DENS_RECIP_W     = 17;
  localparam logic [DENS_RECIP_W-1:0] DENS_RECIP = 17'd104858;
  localparam int DENS_PROD_W      = MV_W + DENS_RECIP_W;

  typedef struct packed {
    logic advance;  // pipeline moves one stage
    logic accept;   // input transfer this cycle
  } pipe_ctrl_t;

endpackage

/* hw/rtl/dsdf_if.sv */
// Channel interfaces for the dust sensor density filter: input, result, config.
// Depends on dsdf_pkg for field widths.
interface dsdf_in_if import dsdf_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ADC_W-1:0] adc_sample;
  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface dsdf_out_if import dsdf_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ADC_W-1:0]  filtered_adc;
  logic [MV_W-1:0]   voltage_mv;
  logic [DENS_W-1:0] density;
  modport source (output valid, output filtered_adc, output voltage_mv,
                  output density, input ready);
  modport sink   (input valid, input filtered_adc, input voltage_mv,
                  input density, output ready);
endinterface

interface dsdf_cfg_if import dsdf_pkg::*;;
  logic                valid;
  logic                ready;
  logic [OFFSET_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/dust_sensor_density_filter_top.sv */
// Top level of the dust sensor density filter: channels, offset register, pipeline.
// Depends on dsdf_pkg, dsdf_if, dsdf_window and dsdf_convert.
//
// Usage:
//   in_ch   carries one 10-bit converter reading per transfer (valid/ready).
//   out_ch  carries one result per reading: the floored mean of the last
//           WINDOW_LEN readings, that mean in millivolts, and the density.
//   cfg_ch  writes offset_mv; it is always ready. Write it only while no
//           reading is in flight.
// From an input transfer to out_ch.valid a reading passes the window sum
// register, loaded at the transfer edge, then the mean, millivolt and
// density registers in turn. Throughput is one reading per cycle while the
// receiver does not stall, set by the single running-sum add and subtract
// and a four-register pipeline (window sum, mean, millivolts, density).
// The first reading after reset fills the whole window and comes out as
// its own mean. Reset empties the pipeline, clears the fill state and
// loads offset_mv with 400 mV; the window contents are not cleared.
// When the receiver stalls, the whole pipeline holds and in_ch.ready
// drops in the same cycle, so no result is lost; up to four readings
// sit in the pipeline.
module dust_sensor_density_filter_top import dsdf_pkg::*; #(
  parameter int WINDOW_LEN = WINDOW_LEN_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  dsdf_in_if.sink    in_ch,
  dsdf_out_if.source out_ch,
  dsdf_cfg_if.sink   cfg_ch
);

  localparam int SUM_W = $clog2(ADC_MAX * WINDOW_LEN + 1);

  pipe_ctrl_t          ctrl;
  logic [OFFSET_W-1:0] offset_r;
  logic                sum_vld;
  logic [SUM_W-1:0]    sum;
  logic                primed;
  logic                out_vld;

  // Advance whenever the result register is empty or being drained.
  assign ctrl.advance = !out_vld || out_ch.ready;
  assign ctrl.accept  = in_ch.valid && ctrl.advance;
  assign in_ch.ready  = ctrl.advance;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_vld;

  // Offset register: take every config transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= OFFSET_RESET;
    end else if (cfg_ch.valid) begin
      offset_r <= cfg_ch.data;
    end
  end

  dsdf_window #(
    .WINDOW_LEN (WINDOW_LEN),
    .SUM_W      (SUM_W)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .sample    (in_ch.adc_sample),
    .sum_vld_r (sum_vld),
    .sum_r     (sum),
    .primed    (primed)
  );

  dsdf_convert #(
    .WINDOW_LEN (WINDOW_LEN),
    .SUM_W      (SUM_W)
  ) u_convert (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (ctrl.advance),
    .sum_vld   (sum_vld),
    .sum       (sum),
    .offset_mv (offset_r),
    .out_vld_r (out_vld),
    .avg_r     (out_ch.filtered_adc),
    .volt_r    (out_ch.voltage_mv),
    .dens_r    (out_ch.density)
  );

  // Once filled, the window stays filled until reset.
  a_primed_holds: assert property (@(posedge clk) disable iff (!rst_n)
    primed |=> primed) else $error("window fill state dropped");

  // Density reads zero whenever the voltage sits below the offset.
  a_dens_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld && out_ch.voltage_mv < offset_r) |-> (out_ch.density == '0))
    else $error("density nonzero below offset");

  // Density never exceeds a fifth of the reported voltage.
  a_dens_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> (MV_W'(out_ch.density) * MV_W'(5) <= out_ch.voltage_mv))
    else $error("density exceeds voltage scale");

  // A result only appears after an input transfer has gone through.
  a_first_after_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> primed) else $error("result before any input transfer");

endmodule

/* hw/rtl/dsdf_window.sv */
// Boxcar window: sample store, running sum and fill state.
// Depends on dsdf_pkg.
module dsdf_window import dsdf_pkg::*; #(
  parameter int WINDOW_LEN = WINDOW_LEN_DEFAULT,
  parameter int SUM_W      = $clog2(ADC_MAX * WINDOW_LEN + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  pipe_ctrl_t       ctrl,
  input  logic [ADC_W-1:0] sample,
  output logic             sum_vld_r,
  output logic [SUM_W-1:0] sum_r,
  output logic             primed
);

  localparam int PTR_W = $clog2(WINDOW_LEN);

  logic [ADC_W-1:0] window_r [WINDOW_LEN];
  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  logic [SUM_W-1:0] run_sum_r, run_sum_nxt;
  logic             primed_r;

  assign primed = primed_r;

  always_comb begin
    if (!primed_r) begin
      run_sum_nxt = SUM_W'(sample) * SUM_W'(WINDOW_LEN);
      ptr_nxt     = '0;
    end else begin
      run_sum_nxt = run_sum_r - SUM_W'(window_r[ptr_r]) + SUM_W'(sample);
      ptr_nxt     = (ptr_r == PTR_W'(WINDOW_LEN - 1)) ? '0 : ptr_r + 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r  <= 1'b0;
      ptr_r     <= '0;
      run_sum_r <= '0;
      sum_vld_r <= 1'b0;
    end else begin
      if (ctrl.accept) begin
        primed_r  <= 1'b1;
        ptr_r     <= ptr_nxt;
        run_sum_r <= run_sum_nxt;
      end
      if (ctrl.advance) begin
        sum_vld_r <= ctrl.accept;
      end
    end
  end

  // Window store and window sum register: the first sample fills every entry.
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        if (!primed_r || ptr_r == PTR_W'(i)) begin
          window_r[i] <= sample;
        end
      end
    end
    if (ctrl.advance && ctrl.accept) begin
      sum_r <= run_sum_nxt;
    end
  end

endmodule

/* hw/rtl/dsdf_convert.sv */
// Mean, millivolt and density stages behind the window sum.
// Depends on dsdf_pkg.
module dsdf_convert import dsdf_pkg::*; #(
  parameter int WINDOW_LEN = WINDOW_LEN_DEFAULT,
  parameter int SUM_W      = $clog2(ADC_MAX * WINDOW_LEN + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic                sum_vld,
  input  logic [SUM_W-1:0]    sum,
  input  logic [OFFSET_W-1:0] offset_mv,
  output logic                out_vld_r,
  output logic [ADC_W-1:0]    avg_r,
  output logic [MV_W-1:0]     volt_r,
  output logic [DENS_W-1:0]   dens_r
);

  // Reciprocal of the window length, exact for any sum below 2^SUM_W.
  localparam int MEAN_SHIFT = SUM_W + $clog2(WINDOW_LEN);
  localparam int MEAN_RECIP = ((1 << MEAN_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam int RECIP_W    = $clog2(MEAN_RECIP + 1);
  localparam int MPROD_W    = SUM_W + RECIP_W;

  logic                   b_vld_r, c_vld_r;
  logic [ADC_W-1:0]       b_avg_r, c_avg_r;
  logic [MV_W-1:0]        c_volt_r, c_diff_r;
  logic [MPROD_W-1:0]     mean_prod;
  logic [SCALED_W-1:0]    scaled;
  logic [MV_W-1:0]        volt;
  logic [DENS_PROD_W-1:0] dens_prod;

  assign mean_prod = MPROD_W'(sum) * MPROD_W'(MEAN_RECIP);
  assign scaled    = SCALED_W'(b_avg_r) * SCALED_W'(MV_FULL_SCALE);
  assign volt      = scaled[SCALED_W-1 -: MV_W];
  assign dens_prod = DENS_PROD_W'(c_diff_r) * DENS_PROD_W'(DENS_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r   <= 1'b0;
      c_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (advance) begin
      b_vld_r   <= sum_vld;
      c_vld_r   <= b_vld_r;
      out_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_avg_r  <= mean_prod[MEAN_SHIFT +: ADC_W];
      c_avg_r  <= b_avg_r;
      c_volt_r <= volt;
      // Clamp below the offset so density reads zero.
      c_diff_r <= (volt >= offset_mv) ? volt - offset_mv : '0;
      avg_r    <= c_avg_r;
      volt_r   <= c_volt_r;
      dens_r   <= dens_prod[DENS_RECIP_SHIFT +: DENS_W];
    end
  end

endmodule
